// ----- hw/rtl/stereo_tempo_delay_core_defines.svh -----
// Assertion macros for the stereo delay RTL.
`ifndef STEREO_TEMPO_DELAY_CORE_DEFINES_SVH
`define STEREO_TEMPO_DELAY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property outside reset.
`define STDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check a property at every edge, reset included.
`define STDC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define STDC_ASSERT(lbl, prop, msg)
`define STDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/stdc_pkg.sv -----
// Types, constants and helpers for the stereo delay core.
package stdc_pkg;

    localparam int ADDR_BITS   = 19;
    localparam int DEPTH       = 1 << ADDR_BITS;
    localparam int SAMPLE_BITS = 24;
    localparam int DELAY_BITS  = ADDR_BITS + 16;
    localparam int HP_BITS     = SAMPLE_BITS + 8;
    localparam int HPO_BITS    = SAMPLE_BITS + 2;
    localparam int ACC_BITS    = 64;
    localparam int MUL_A_BITS  = 33;
    localparam int MUL_B_BITS  = 23;
    localparam int SPLIT_BITS  = 18;
    localparam int SPB_BITS    = 28;
    localparam int TGT_BITS    = SPB_BITS + 10;
    localparam int GAIN_BITS   = 17;
    localparam int COEF_BITS   = 16;
    localparam int CHOICE_BITS = 3;
    localparam int CFG_BITS    = 28;
    localparam int IDX_BITS    = 3;

    localparam logic [21:0] GLIDE_K = 22'd2147484;
    localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(65536);
    localparam logic [CHOICE_BITS-1:0] CHOICE_MAX = 3'd4;
    localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(64'd24000 << 16);
    localparam logic [TGT_BITS-1:0] TGT_LO = TGT_BITS'(64'd1 << 16);
    localparam logic [TGT_BITS-1:0] TGT_HI = TGT_BITS'(64'(DEPTH - 2) << 16);
    localparam logic signed [ACC_BITS-1:0] LIMIT_FOUR = ACC_BITS'(64'sd1 <<< (SAMPLE_BITS - 2));
    localparam logic signed [ACC_BITS-1:0] OUT_MAX = ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] OUT_MIN = -(ACC_BITS'(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Register indexes on the configuration port
    localparam logic [IDX_BITS-1:0] REG_SPB  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_TCL  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_TCR  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_FBG  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_HPC  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_WET  = 3'd5;

    typedef struct packed {
        logic                   rd_en;
        logic [ADDR_BITS-1:0]   rd_addr;
        logic                   wr_en;
        logic [ADDR_BITS-1:0]   wr_addr;
        logic [SAMPLE_BITS-1:0] wr_data;
    } line_req_t;

    // Shift right with rounding to nearest, halves away from zero
    function automatic logic signed [ACC_BITS-1:0] rnd_shift(
        input logic signed [ACC_BITS-1:0] v, input int unsigned sh);
        logic [ACC_BITS-1:0] mag;
        logic [ACC_BITS-1:0] r;
        mag = v[ACC_BITS-1] ? ACC_BITS'(-v) : ACC_BITS'(v);
        r = (mag + (ACC_BITS'(1) << (sh - 1))) >> sh;
        return v[ACC_BITS-1] ? -$signed(r) : $signed(r);
    endfunction

endpackage

// ----- hw/rtl/stdc_line.sv -----
// One channel's circular delay line memory.
module stdc_line (
    input  logic                           aclk,
    input  stdc_pkg::line_req_t            req,
    output logic [stdc_pkg::SAMPLE_BITS-1:0] rd_data
);
    import stdc_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [DEPTH];

    // Write one sample
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read with registered data
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end
endmodule

// ----- hw/rtl/stereo_tempo_delay_core.sv -----
// Tempo-synced stereo feedback delay: sequencer, shared multiplier and two lines.
//
// One stereo frame is taken per transaction and one mixed frame returned. The
// two channels run one after the other through a single shared multiplier and
// accumulator under a step sequencer, and each line memory sees two reads and
// one write per frame. A new frame is taken only after the result of the last
// one has been published; s_ready is low while a frame is in work. The lines
// start as all zeros without a clearing pass: an entry not yet written since
// reset reads as zero, tracked from the write pointer and a wrap flag.
// Configuration writes are taken at any cycle and should be made while the
// block is idle.
`include "stereo_tempo_delay_core_defines.svh"

module stereo_tempo_delay_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [stdc_pkg::IDX_BITS-1:0]         cfg_index,
    input  logic [stdc_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [stdc_pkg::SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [stdc_pkg::SAMPLE_BITS-1:0] s_right_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [stdc_pkg::SAMPLE_BITS-1:0] m_left_out,
    output logic signed [stdc_pkg::SAMPLE_BITS-1:0] m_right_out
);
    import stdc_pkg::*;

    typedef enum logic [21:0] {
        S_IDLE   = 22'(1) << 0,
        S_TGT    = 22'(1) << 1,
        S_DIFF   = 22'(1) << 2,
        S_GLO    = 22'(1) << 3,
        S_GHI    = 22'(1) << 4,
        S_GUPD   = 22'(1) << 5,
        S_POS    = 22'(1) << 6,
        S_RD0    = 22'(1) << 7,
        S_RD1    = 22'(1) << 8,
        S_RD2    = 22'(1) << 9,
        S_INTERP = 22'(1) << 10,
        S_DLY    = 22'(1) << 11,
        S_HP1    = 22'(1) << 12,
        S_HP2    = 22'(1) << 13,
        S_HP3    = 22'(1) << 14,
        S_HPO    = 22'(1) << 15,
        S_FB     = 22'(1) << 16,
        S_WR     = 22'(1) << 17,
        S_MIX1   = 22'(1) << 18,
        S_MIX2   = 22'(1) << 19,
        S_OUT    = 22'(1) << 20,
        S_DONE   = 22'(1) << 21
    } state_t;

    // Configuration registers
    logic [SPB_BITS-1:0]    spb_reg;
    logic [CHOICE_BITS-1:0] tcl_reg, tcr_reg;
    logic [GAIN_BITS-1:0]   fbg_reg, wet_reg;
    logic [COEF_BITS-1:0]   hpc_reg;

    // Control and channel state
    state_t                  state_reg, state_next;
    logic                    ch_reg;
    logic [ADDR_BITS-1:0]    wp_reg;
    logic                    wrapped_reg;
    logic [DELAY_BITS-1:0]   delay_reg [2];
    logic signed [HP_BITS-1:0] hp_reg [2];

    // Datapath registers
    logic signed [SAMPLE_BITS-1:0] in_reg [2];
    logic signed [SAMPLE_BITS-1:0] res_reg [2];
    logic [DELAY_BITS-1:0]   target_reg;
    logic                    neg_reg;
    logic [DELAY_BITS-1:0]   mag_reg;
    logic [DELAY_BITS-1:0]   pos_reg;
    logic                    v0_reg, v1_reg;
    logic signed [SAMPLE_BITS-1:0] l0_reg, l1_reg, delayed_reg;
    logic signed [HPO_BITS-1:0] hpo_reg;
    logic signed [ACC_BITS-1:0] acc_reg;

    // Lines
    line_req_t               req_l, req_r, req;
    logic [SAMPLE_BITS-1:0]  rd_l, rd_r;
    logic signed [SAMPLE_BITS-1:0] rd_cur;

    // Shared multiplier
    logic signed [MUL_A_BITS-1:0]            mul_a;
    logic signed [MUL_B_BITS-1:0]            mul_b;
    logic signed [MUL_A_BITS+MUL_B_BITS-1:0] mul_p;
    logic signed [ACC_BITS-1:0]              prod;

    // Step helpers
    logic [CHOICE_BITS-1:0]  choice;
    logic [TGT_BITS-1:0]     raw_tgt;
    logic signed [DELAY_BITS:0] diff;
    logic [DELAY_BITS-1:0]   glide_r;
    logic [GAIN_BITS-1:0]    wet_sat;
    logic [ADDR_BITS-1:0]    i0, i1;
    logic signed [SAMPLE_BITS:0] ldiff;
    logic signed [ACC_BITS-1:0] fb_sum, mix_sum;
    logic [SAMPLE_BITS-1:0]  fb_clamped;
    logic signed [SAMPLE_BITS-1:0] in_cur;
    logic                    out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid || m_ready;
    assign in_cur   = in_reg[ch_reg];
    assign i0       = pos_reg[DELAY_BITS-1:16];
    assign i1       = i0 + 1'b1;
    assign rd_cur   = ch_reg ? $signed(rd_r) : $signed(rd_l);
    assign wet_sat  = (wet_reg > UNITY) ? UNITY : wet_reg;
    assign ldiff    = {l1_reg[SAMPLE_BITS-1], l1_reg} - {l0_reg[SAMPLE_BITS-1], l0_reg};

    // Compute the clamped delay target
    always_comb begin
        choice  = ch_reg ? tcr_reg : tcl_reg;
        if (choice > CHOICE_MAX) begin
            choice = CHOICE_MAX;
        end
        raw_tgt = TGT_BITS'(spb_reg) << (4'd6 + 4'(choice));
        if (raw_tgt < TGT_LO) begin
            raw_tgt = TGT_LO;
        end else if (raw_tgt > TGT_HI) begin
            raw_tgt = TGT_HI;
        end
    end

    assign diff    = $signed({1'b0, target_reg}) - $signed({1'b0, delay_reg[ch_reg]});
    assign glide_r = DELAY_BITS'((acc_reg + (ACC_BITS'(1) <<< 31)) >>> 32);

    // Select multiplier operands for the current step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_GLO: begin
                mul_a = MUL_A_BITS'(mag_reg[SPLIT_BITS-1:0]);
                mul_b = MUL_B_BITS'(GLIDE_K);
            end
            S_GHI: begin
                mul_a = MUL_A_BITS'(mag_reg[DELAY_BITS-1:SPLIT_BITS]);
                mul_b = MUL_B_BITS'(GLIDE_K);
            end
            S_INTERP: begin
                mul_a = MUL_A_BITS'(ldiff);
                mul_b = MUL_B_BITS'({1'b0, pos_reg[15:0]});
            end
            S_HP1: begin
                mul_a = MUL_A_BITS'(hp_reg[ch_reg]);
                mul_b = MUL_B_BITS'({1'b0, hpc_reg});
            end
            S_HP2: begin
                mul_a = MUL_A_BITS'(delayed_reg);
                mul_b = MUL_B_BITS'(UNITY - {1'b0, hpc_reg});
            end
            S_FB: begin
                mul_a = MUL_A_BITS'(hpo_reg);
                mul_b = MUL_B_BITS'(fbg_reg);
            end
            S_MIX1: begin
                mul_a = MUL_A_BITS'(in_cur);
                mul_b = MUL_B_BITS'(UNITY - wet_sat);
            end
            S_MIX2: begin
                mul_a = MUL_A_BITS'(delayed_reg);
                mul_b = MUL_B_BITS'(wet_sat);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign prod  = ACC_BITS'(mul_p);

    // Feedback and mix results with clamping
    always_comb begin
        fb_sum = ACC_BITS'(in_cur) + rnd_shift(acc_reg, 16);
        if (fb_sum > LIMIT_FOUR) begin
            fb_sum = LIMIT_FOUR;
        end else if (fb_sum < -LIMIT_FOUR) begin
            fb_sum = -LIMIT_FOUR;
        end
        fb_clamped = SAMPLE_BITS'(fb_sum);
        mix_sum = rnd_shift(acc_reg, 16);
        if (mix_sum > OUT_MAX) begin
            mix_sum = OUT_MAX;
        end else if (mix_sum < OUT_MIN) begin
            mix_sum = OUT_MIN;
        end
    end

    // Drive the line ports
    always_comb begin
        req.rd_en   = (state_reg == S_RD0) || (state_reg == S_RD1);
        req.rd_addr = (state_reg == S_RD1) ? i1 : i0;
        req.wr_en   = (state_reg == S_WR);
        req.wr_addr = wp_reg;
        req.wr_data = fb_clamped;
        req_l       = req;
        req_r       = req;
        req_l.rd_en = req.rd_en && !ch_reg;
        req_l.wr_en = req.wr_en && !ch_reg;
        req_r.rd_en = req.rd_en && ch_reg;
        req_r.wr_en = req.wr_en && ch_reg;
    end

    stdc_line u_line_l (.aclk(aclk), .req(req_l), .rd_data(rd_l));
    stdc_line u_line_r (.aclk(aclk), .req(req_r), .rd_data(rd_r));

    // Sequence the steps
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_TGT;
            S_TGT:    state_next = S_DIFF;
            S_DIFF:   state_next = S_GLO;
            S_GLO:    state_next = S_GHI;
            S_GHI:    state_next = S_GUPD;
            S_GUPD:   state_next = S_POS;
            S_POS:    state_next = S_RD0;
            S_RD0:    state_next = S_RD1;
            S_RD1:    state_next = S_RD2;
            S_RD2:    state_next = S_INTERP;
            S_INTERP: state_next = S_DLY;
            S_DLY:    state_next = S_HP1;
            S_HP1:    state_next = S_HP2;
            S_HP2:    state_next = S_HP3;
            S_HP3:    state_next = S_HPO;
            S_HPO:    state_next = S_FB;
            S_FB:     state_next = S_WR;
            S_WR:     state_next = S_MIX1;
            S_MIX1:   state_next = S_MIX2;
            S_MIX2:   state_next = S_OUT;
            S_OUT:    state_next = ch_reg ? S_DONE : S_TGT;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ch_reg       <= 1'b0;
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            m_valid      <= 1'b0;
            delay_reg[0] <= DELAY_RESET;
            delay_reg[1] <= DELAY_RESET;
            hp_reg[0]    <= '0;
            hp_reg[1]    <= '0;
            spb_reg      <= SPB_BITS'(6144000);
            tcl_reg      <= 3'd2;
            tcr_reg      <= 3'd2;
            fbg_reg      <= GAIN_BITS'(19661);
            hpc_reg      <= COEF_BITS'(64684);
            wet_reg      <= GAIN_BITS'(32768);
        end else begin
            state_reg <= state_next;
            // Take configuration writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_SPB: spb_reg <= cfg_data;
                    REG_TCL: tcl_reg <= cfg_data[CHOICE_BITS-1:0];
                    REG_TCR: tcr_reg <= cfg_data[CHOICE_BITS-1:0];
                    REG_FBG: fbg_reg <= cfg_data[GAIN_BITS-1:0];
                    REG_HPC: hpc_reg <= cfg_data[COEF_BITS-1:0];
                    REG_WET: wet_reg <= cfg_data[GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            // Raise the result when published, drop it once taken
            if (state_reg == S_DONE && out_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:  ch_reg <= 1'b0;
                S_GUPD:  delay_reg[ch_reg] <= neg_reg ? delay_reg[ch_reg] - glide_r
                                                      : delay_reg[ch_reg] + glide_r;
                S_HP3:   hp_reg[ch_reg] <= HP_BITS'(rnd_shift(acc_reg, 16));
                S_OUT:   ch_reg <= 1'b1;
                S_DONE: begin
                    // Advance the write pointer with the published frame
                    if (out_free) begin
                        wp_reg  <= wp_reg + 1'b1;
                        if (&wp_reg) begin
                            wrapped_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_reg[0] <= s_left_in;
                    in_reg[1] <= s_right_in;
                end
            end
            S_TGT:  target_reg <= DELAY_BITS'(raw_tgt);
            S_DIFF: begin
                neg_reg <= diff[DELAY_BITS];
                mag_reg <= diff[DELAY_BITS] ? DELAY_BITS'(-diff) : DELAY_BITS'(diff);
            end
            S_GLO:    acc_reg <= prod;
            S_GHI:    acc_reg <= acc_reg + (prod <<< SPLIT_BITS);
            S_POS:    pos_reg <= {wp_reg, 16'b0} - delay_reg[ch_reg];
            S_RD0:    v0_reg <= wrapped_reg || (i0 < wp_reg);
            S_RD1: begin
                v1_reg <= wrapped_reg || (i1 < wp_reg);
                l0_reg <= v0_reg ? rd_cur : '0;
            end
            S_RD2:    l1_reg <= v1_reg ? rd_cur : '0;
            S_INTERP: acc_reg <= prod;
            S_DLY:    delayed_reg <= SAMPLE_BITS'(ACC_BITS'(l0_reg) + rnd_shift(acc_reg, 16));
            S_HP1:    acc_reg <= prod;
            S_HP2:    acc_reg <= acc_reg + (prod <<< 8);
            S_HPO:    hpo_reg <= HPO_BITS'(ACC_BITS'(delayed_reg) -
                                           rnd_shift(ACC_BITS'(hp_reg[ch_reg]), 8));
            S_FB:     acc_reg <= prod;
            S_MIX1:   acc_reg <= prod;
            S_MIX2:   acc_reg <= acc_reg + prod;
            S_OUT:    res_reg[ch_reg] <= SAMPLE_BITS'(mix_sum);
            S_DONE: begin
                if (out_free) begin
                    m_left_out  <= res_reg[0];
                    m_right_out <= res_reg[1];
                end
            end
            default: ;
        endcase
    end

    // Assertions
    `STDC_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid && s_ready, "not idle after reset")
    `STDC_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready && !ch_reg,
                 "accepted frame did not start on the left channel")
    `STDC_ASSERT(a_wp_advance,
                 state_reg == S_DONE && out_free |=> wp_reg == $past(wp_reg) + 1'b1,
                 "write pointer did not advance with the result")
endmodule

// ----- tb/stereo_tempo_delay_core_checker.sv -----
// Frame predictor and result scoreboard for the stereo tempo delay core.
module stereo_tempo_delay_core_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [stdc_pkg::IDX_BITS-1:0]           cfg_index,
    input  logic [stdc_pkg::CFG_BITS-1:0]           cfg_data,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic signed [stdc_pkg::SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [stdc_pkg::SAMPLE_BITS-1:0] s_right_in,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic signed [stdc_pkg::SAMPLE_BITS-1:0] m_left_out,
    input  logic signed [stdc_pkg::SAMPLE_BITS-1:0] m_right_out,
    output int                                      fail_count,
    output int                                      frames_waiting,
    output int                                      frames_checked
);
    import stdc_pkg::*;

    localparam longint LINE_LEN = longint'(DEPTH);
    localparam longint GLIDE    = 2147484;
    localparam longint ONE_Q16  = 65536;
    localparam longint FOUR     = longint'(1) << (SAMPLE_BITS - 2);
    localparam longint OUT_HI   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_LO   = -(longint'(1) << (SAMPLE_BITS - 1));

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } stereo_frame_t;

    // Predicted state: two echo lines, glide, high-pass and write pointer
    int          echo_mem [2][DEPTH];
    longint      glide_pos [2];
    longint      hp_acc [2];
    int unsigned wr_ptr;

    // Shadow of the configuration registers
    longint beat_len;
    longint note_sel [2];
    longint fb_gain;
    longint hp_pole;
    longint wet_mix;

    stereo_frame_t mix_fifo [$];

    // Round to nearest, halves away from zero
    function automatic longint round_shift(longint v, int sh);
        longint half;
        half = longint'(1) << (sh - 1);
        if (v >= 0) return (v + half) >>> sh;
        return -((-v + half) >>> sh);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Advance one channel by one sample and return the mixed output
    function automatic longint echo_channel(int c, longint x);
        longint sel, target, total, d, pos, tap, hp_out, fb, w, mix;
        int unsigned i0, i1;
        longint frac;
        sel    = note_sel[c] > 4 ? 4 : note_sel[c];
        target = beat_len << (6 + sel);
        total  = LINE_LEN << 16;
        target = clip(target, longint'(1) << 16, (LINE_LEN - 2) << 16);
        glide_pos[c] += round_shift((target - glide_pos[c]) * GLIDE, 32);
        d = glide_pos[c] % total;
        if (d < 0) d += total;
        pos = (longint'(wr_ptr) << 16) + total - d;
        if (pos >= total) pos -= total;
        i0   = int'((pos >> 16) % LINE_LEN);
        i1   = int'((longint'(i0) + 1) % LINE_LEN);
        frac = pos & 64'hFFFF;
        tap  = longint'(echo_mem[c][i0]) +
               round_shift((longint'(echo_mem[c][i1]) - longint'(echo_mem[c][i0])) * frac, 16);
        hp_acc[c] = round_shift(hp_pole * hp_acc[c] + (ONE_Q16 - hp_pole) * (tap * 256), 16);
        hp_out = tap - round_shift(hp_acc[c], 8);
        fb = x + round_shift(hp_out * fb_gain, 16);
        echo_mem[c][wr_ptr] = int'(clip(fb, -FOUR, FOUR));
        w   = wet_mix > ONE_Q16 ? ONE_Q16 : wet_mix;
        mix = round_shift(x * (ONE_Q16 - w) + tap * w, 16);
        return clip(mix, OUT_LO, OUT_HI);
    endfunction

    // Track configuration, predict accepted frames, compare returned frames
    always @(posedge aclk) begin
        stereo_frame_t want;
        stereo_frame_t got;
        if (!aresetn) begin
            glide_pos[0] = longint'(24000) << 16;
            glide_pos[1] = longint'(24000) << 16;
            hp_acc[0]    = 0;
            hp_acc[1]    = 0;
            wr_ptr       = 0;
            beat_len     = 6144000;
            note_sel[0]  = 2;
            note_sel[1]  = 2;
            fb_gain      = 19661;
            hp_pole      = 64684;
            wet_mix      = 32768;
            mix_fifo.delete();
            fail_count     <= 0;
            frames_checked <= 0;
            frames_waiting <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SPB: beat_len    = longint'(cfg_data[SPB_BITS-1:0]);
                    REG_TCL: note_sel[0] = longint'(cfg_data[CHOICE_BITS-1:0]);
                    REG_TCR: note_sel[1] = longint'(cfg_data[CHOICE_BITS-1:0]);
                    REG_FBG: fb_gain     = longint'(cfg_data[GAIN_BITS-1:0]);
                    REG_HPC: hp_pole     = longint'(cfg_data[COEF_BITS-1:0]);
                    REG_WET: wet_mix     = longint'(cfg_data[GAIN_BITS-1:0]);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.left  = m_left_out;
                got.right = m_right_out;
                if (mix_fifo.size() == 0) begin
                    $error("output transaction with no frame pending: left %0d right %0d",
                           got.left, got.right);
                    fail_count <= fail_count + 1;
                end else begin
                    want = mix_fifo.pop_front();
                    frames_checked <= frames_checked + 1;
                    if (got.left !== want.left || got.right !== want.right)
                        fail_count <= fail_count + 1;
                    if (got.left !== want.left)
                        $error("left_out: expected %0d, actual %0d", want.left, got.left);
                    if (got.right !== want.right)
                        $error("right_out: expected %0d, actual %0d", want.right, got.right);
                end
            end
            if (s_valid && s_ready) begin
                want.left  = SAMPLE_BITS'(echo_channel(0, longint'(s_left_in)));
                want.right = SAMPLE_BITS'(echo_channel(1, longint'(s_right_in)));
                wr_ptr = (wr_ptr + 1) % DEPTH;
                mix_fifo.push_back(want);
            end
            frames_waiting <= mix_fifo.size();
        end
    end

endmodule

// ----- tb/stereo_tempo_delay_core_tb.sv -----
// Stimulus, handshake pacing and verdict for the stereo tempo delay core.
module stereo_tempo_delay_core_tb;
    import stdc_pkg::*;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [IDX_BITS-1:0]           cfg_index = '0;
    logic [CFG_BITS-1:0]           cfg_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_left_in = '0;
    logic signed [SAMPLE_BITS-1:0] s_right_in = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_left_out;
    logic signed [SAMPLE_BITS-1:0] m_right_out;

    int fail_count;
    int frames_waiting;
    int frames_checked;
    bit pacing_on = 1'b1;
    int frames_sent = 0;
    int stall_left = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    stereo_tempo_delay_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_left_in(s_left_in), .s_right_in(s_right_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_left_out(m_left_out), .m_right_out(m_right_out)
    );

    stereo_tempo_delay_core_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_left_in(s_left_in), .s_right_in(s_right_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_left_out(m_left_out), .m_right_out(m_right_out),
        .fail_count(fail_count), .frames_waiting(frames_waiting),
        .frames_checked(frames_checked)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if (!pacing_on || $urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return SAMPLE_BITS'($urandom_range(0, 255)) - 24'd128;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Stall the result side at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_left_in  <= l;
        s_right_in <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        frames_sent++;
    endtask

    // Drop valid and let every pending frame drain before touching registers
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frames_waiting != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic load_setting(input logic [CFG_BITS-1:0] spb, input logic [2:0] tl,
                                input logic [2:0] tr, input logic [16:0] fb,
                                input logic [15:0] hp, input logic [16:0] wet);
        write_reg(REG_SPB, spb);
        write_reg(REG_TCL, CFG_BITS'(tl));
        write_reg(REG_TCR, CFG_BITS'(tr));
        write_reg(REG_FBG, CFG_BITS'(fb));
        write_reg(REG_HPC, CFG_BITS'(hp));
        write_reg(REG_WET, CFG_BITS'(wet));
    endtask

    logic [SAMPLE_BITS-1:0] edge_vals [6] = '{24'h7FFFFF, 24'h800000, 24'h000000,
                                             24'hFFFFFF, 24'h000001, 24'h400000};

    initial begin
        logic [16:0] fb_pick, wet_pick;
        logic [15:0] hp_pick;
        logic [CFG_BITS-1:0] spb_pick;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: sample extremes under reset settings
        foreach (edge_vals[i])
            foreach (edge_vals[j])
                if (j < 3) send_frame(edge_vals[i], edge_vals[(i + j) % 6]);
        drain();

        // Extreme settings: out-of-range note choices, saturating wet and gain
        load_setting('0, 3'd7, 3'd5, 17'h1FFFF, 16'hFFFF, 17'h1FFFF);
        repeat (4) send_frame(24'h7FFFFF, 24'h800000);
        drain();

        // Glide toward a one-sample delay, back to back and then paced
        pacing_on = 1'b0;
        load_setting(CFG_BITS'(200), 3'd0, 3'd1, 17'd78643, 16'd0, 17'd65536);
        repeat (150) send_frame(pick_sample(), pick_sample());
        drain();
        pacing_on = 1'b1;
        load_setting(CFG_BITS'(90), 3'd1, 3'd0, 17'd60000, 16'd40000, 17'd50000);
        repeat (150) send_frame(pick_sample(), pick_sample());
        drain();

        // Random settings, extremes mixed in
        for (int ph = 0; ph < 9; ph++) begin
            case ($urandom_range(0, 3))
                0: spb_pick = '0;
                1: spb_pick = 28'hFFFFFFF;
                default: spb_pick = CFG_BITS'($urandom_range(0, 8000000));
            endcase
            fb_pick  = ($urandom_range(0, 3) == 0) ? 17'd78643 : 17'($urandom_range(0, 78643));
            hp_pick  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
            case ($urandom_range(0, 3))
                0: wet_pick = 17'd0;
                1: wet_pick = 17'd65536;
                default: wet_pick = 17'($urandom);
            endcase
            load_setting(spb_pick, 3'($urandom), 3'($urandom), fb_pick, hp_pick, wet_pick);
            pacing_on = (ph % 3) != 2;
            repeat (64) send_frame(pick_sample(), pick_sample());
            drain();
        end

        $display("Sent %0d stereo frames, %0d checked, over note lengths, glide, feedback",
                 frames_sent, frames_checked);
        $display("and wet/dry settings including saturating extremes and random stalls.");
        if (fail_count == 0)
            $display("stereo_tempo_delay_core_tb: clean");
        else
            $display("stereo_tempo_delay_core_tb: errors");
        $finish;
    end

    initial begin
        #12000000;
        $display("stereo_tempo_delay_core_tb: errors");
        $finish;
    end

endmodule
